FILE: design/primitive_inertia_tensor_core_assert.svh
// assertion macros shared by the core
`ifndef PRIMITIVE_INERTIA_TENSOR_CORE_ASSERT_SVH
`define PRIMITIVE_INERTIA_TENSOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PIT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PIT_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PIT_ASSERT(name, prop, msg)
`define PIT_ASSERT_RST(name, prop, msg)
`endif

`endif

FILE: design/pit_pkg.sv
package pit_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 24;
    localparam int KIND_W    = 3;
    localparam int OUT_W     = 32;
    localparam int LANES     = 3;
    localparam int SQ_W      = 2 * DIM_W;
    localparam int COEF_W    = 31;
    localparam int S_W       = 27;
    localparam int PART_W    = DIM_W + COEF_W;
    localparam int NUM_W     = 80;
    localparam int DIV_W     = OUT_W + FRAC_BITS;
    localparam int REM_W     = (DIV_W + OUT_W + 1 > NUM_W + 1) ? DIV_W + OUT_W + 1 : NUM_W + 1;

    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BOX      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPHERE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CAPSULE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CYLINDER = 3'd4;

    localparam logic [DIV_W-1:0] DEN_ONE    = DIV_W'(1);
    localparam logic [DIV_W-1:0] DEN_TWO    = DIV_W'(2) << FRAC_BITS;
    localparam logic [DIV_W-1:0] DEN_FIVE   = DIV_W'(5) << FRAC_BITS;
    localparam logic [DIV_W-1:0] DEN_TWELVE = DIV_W'(12) << FRAC_BITS;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_op;

endpackage

FILE: design/pit_front.sv
module pit_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [pit_pkg::KIND_W-1:0]             i_opcode,
    input  logic [pit_pkg::DIM_W-1:0]              i_box_length,
    input  logic [pit_pkg::DIM_W-1:0]              i_box_width,
    input  logic [pit_pkg::DIM_W-1:0]              i_shape_height,
    input  logic [pit_pkg::DIM_W-1:0]              i_shape_radius,
    output logic                                   o_valid,
    output pit_pkg::t_div_op [pit_pkg::LANES-1:0]  o_ops
);
    import pit_pkg::*;

    // stage 1: squares and linear coefficients
    logic              r1_v;
    logic [KIND_W-1:0] r1_kind;
    logic [SQ_W-1:0]   r1_l2, r1_w2, r1_h2, r1_r2;
    logic [S_W-1:0]    r1_s;
    logic [COEF_W-1:0] r1_a1, r1_a2, r1_a3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_opcode;
            r1_l2   <= SQ_W'(i_box_length) * SQ_W'(i_box_length);
            r1_w2   <= SQ_W'(i_box_width) * SQ_W'(i_box_width);
            r1_h2   <= SQ_W'(i_shape_height) * SQ_W'(i_shape_height);
            r1_r2   <= SQ_W'(i_shape_radius) * SQ_W'(i_shape_radius);
            r1_s    <= S_W'(i_shape_height) * S_W'(3) + S_W'(i_shape_radius) * S_W'(4);
            r1_a1   <= COEF_W'(i_shape_height) * COEF_W'(5)
                     + COEF_W'(i_shape_radius) * COEF_W'(40);
            r1_a2   <= COEF_W'(i_shape_height) * COEF_W'(45)
                     + COEF_W'(i_shape_radius) * COEF_W'(32);
            r1_a3   <= COEF_W'(i_shape_height) * COEF_W'(15)
                     + COEF_W'(i_shape_radius) * COEF_W'(16);
        end
    end

    // stage 2: partial products of the capsule cubics, split at DIM_W
    logic              r2_v;
    logic [KIND_W-1:0] r2_kind;
    logic [SQ_W-1:0]   r2_l2, r2_w2, r2_h2, r2_r2;
    logic [S_W-1:0]    r2_s;
    logic [PART_W-1:0] r2_p1l, r2_p1h, r2_p2l, r2_p2h, r2_p3l, r2_p3h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_kind <= r1_kind;
            r2_l2   <= r1_l2;
            r2_w2   <= r1_w2;
            r2_h2   <= r1_h2;
            r2_r2   <= r1_r2;
            r2_s    <= r1_s;
            r2_p1l  <= PART_W'(r1_h2[DIM_W-1:0]) * PART_W'(r1_a1);
            r2_p1h  <= PART_W'(r1_h2[SQ_W-1:DIM_W]) * PART_W'(r1_a1);
            r2_p2l  <= PART_W'(r1_r2[DIM_W-1:0]) * PART_W'(r1_a2);
            r2_p2h  <= PART_W'(r1_r2[SQ_W-1:DIM_W]) * PART_W'(r1_a2);
            r2_p3l  <= PART_W'(r1_r2[DIM_W-1:0]) * PART_W'(r1_a3);
            r2_p3h  <= PART_W'(r1_r2[SQ_W-1:DIM_W]) * PART_W'(r1_a3);
        end
    end

    // stage 3: capsule numerators
    logic              r3_v;
    logic [KIND_W-1:0] r3_kind;
    logic [SQ_W-1:0]   r3_l2, r3_w2, r3_h2, r3_r2;
    logic [S_W-1:0]    r3_s;
    logic [NUM_W-1:0]  r3_px, r3_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_kind <= r2_kind;
            r3_l2   <= r2_l2;
            r3_w2   <= r2_w2;
            r3_h2   <= r2_h2;
            r3_r2   <= r2_r2;
            r3_s    <= r2_s;
            r3_px   <= (NUM_W'(r2_p1h) << DIM_W) + NUM_W'(r2_p1l)
                     + (NUM_W'(r2_p2h) << DIM_W) + NUM_W'(r2_p2l);
            r3_pz   <= (NUM_W'(r2_p3h) << DIM_W) + NUM_W'(r2_p3l);
        end
    end

    // stage 4: pick numerator and divisor per lane, add half divisor for rounding
    t_div_op [LANES-1:0] n_raw;
    t_div_op [LANES-1:0] n_ops;
    logic [DIV_W-1:0]    cap_den;
    logic                r4_v;
    t_div_op [LANES-1:0] r4_ops;

    assign cap_den = (DIV_W'(r3_s) * DIV_W'(20)) << FRAC_BITS;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_raw[k].num = '0;
            n_raw[k].den = DEN_ONE;
        end
        unique case (r3_kind)
            KIND_BOX: begin
                n_raw[0].num = NUM_W'(r3_w2) + NUM_W'(r3_h2);
                n_raw[1].num = NUM_W'(r3_l2) + NUM_W'(r3_h2);
                n_raw[2].num = NUM_W'(r3_w2) + NUM_W'(r3_l2);
                for (int k = 0; k < LANES; k++) begin
                    n_raw[k].den = DEN_TWELVE;
                end
            end
            KIND_SPHERE: begin
                for (int k = 0; k < LANES; k++) begin
                    n_raw[k].num = NUM_W'(r3_r2) << 1;
                    n_raw[k].den = DEN_FIVE;
                end
            end
            KIND_CAPSULE: begin
                // empty capsule stays at zero over a unit divisor
                if (r3_s != '0) begin
                    n_raw[0].num = r3_px;
                    n_raw[1].num = r3_px;
                    n_raw[2].num = r3_pz;
                    n_raw[0].den = cap_den;
                    n_raw[1].den = cap_den;
                    n_raw[2].den = cap_den >> 1;
                end
            end
            KIND_CYLINDER: begin
                n_raw[0].num = NUM_W'(r3_r2) * NUM_W'(3) + NUM_W'(r3_h2);
                n_raw[1].num = NUM_W'(r3_r2) * NUM_W'(3) + NUM_W'(r3_h2);
                n_raw[2].num = NUM_W'(r3_r2);
                n_raw[0].den = DEN_TWELVE;
                n_raw[1].den = DEN_TWELVE;
                n_raw[2].den = DEN_TWO;
            end
            default: begin
            end
        endcase
        for (int k = 0; k < LANES; k++) begin
            n_ops[k].den = n_raw[k].den;
            n_ops[k].num = n_raw[k].num + NUM_W'(n_raw[k].den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ops <= n_ops;
        end
    end

    assign o_valid = r4_v;
    assign o_ops   = r4_ops;

endmodule

FILE: design/pit_div.sv
module pit_div (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  pit_pkg::t_div_op [pit_pkg::LANES-1:0]       i_ops,
    output logic                                        o_valid,
    output logic [pit_pkg::LANES-1:0][pit_pkg::OUT_W-1:0] o_quot,
    output logic                                        o_sat
);
    import pit_pkg::*;

    logic [REM_W-1:0] r_rem [OUT_W][LANES];
    logic [DIV_W-1:0] r_den [OUT_W][LANES];
    logic [OUT_W-1:0] r_q   [OUT_W+1][LANES];
    logic [LANES-1:0] r_sat [OUT_W+1];
    logic             r_v   [OUT_W+1];

    // entry stage: quotient too large for OUT_W bits saturates
    logic [LANES-1:0] n_sat0;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_sat0[k] = REM_W'(i_ops[k].num) >= (REM_W'(i_ops[k].den) << OUT_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= n_sat0;
            for (int k = 0; k < LANES; k++) begin
                r_rem[0][k] <= n_sat0[k] ? '0 : REM_W'(i_ops[k].num);
                r_den[0][k] <= i_ops[k].den;
                r_q[0][k]   <= '0;
            end
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < OUT_W; j++) begin : g_step
        localparam int BIT = OUT_W - 1 - j;
        logic [REM_W-1:0] trial [LANES];
        logic [LANES-1:0] ge;
        logic [OUT_W-1:0] n_q [LANES];

        always_comb begin
            for (int k = 0; k < LANES; k++) begin
                trial[k] = REM_W'(r_den[j][k]) << BIT;
                ge[k]    = r_rem[j][k] >= trial[k];
                n_q[k]      = r_q[j][k];
                n_q[k][BIT] = ge[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[j+1] <= r_sat[j];
                for (int k = 0; k < LANES; k++) begin
                    r_q[j+1][k] <= n_q[k];
                end
            end
        end

        if (j < OUT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int k = 0; k < LANES; k++) begin
                        r_rem[j+1][k] <= ge[k] ? r_rem[j][k] - trial[k] : r_rem[j][k];
                        r_den[j+1][k] <= r_den[j][k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            o_quot[k] = r_sat[OUT_W][k] ? '1 : r_q[OUT_W][k];
        end
    end

    assign o_sat   = |r_sat[OUT_W];
    assign o_valid = r_v[OUT_W];

endmodule

FILE: design/primitive_inertia_tensor_core.sv
// channel | direction | handshake                | payload
// in      | sink      | i_in_valid / o_in_stall  | opcode, box_length, box_width, height, radius
// out     | source    | o_out_valid / i_out_stall| inertia_x, inertia_y, inertia_z, saturated
//
// one beat per cycle while the result is not stalled; 4 front stages, 33 divider stages
// the divider retires one quotient bit per stage in each of three lanes
// reset is synchronous and empties every stage
// a stalled result freezes the whole pipeline; bubbles do not collapse
`include "primitive_inertia_tensor_core_assert.svh"

module primitive_inertia_tensor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pit_pkg::KIND_W-1:0]    i_opcode,
    input  logic [pit_pkg::DIM_W-1:0]     i_box_length,
    input  logic [pit_pkg::DIM_W-1:0]     i_box_width,
    input  logic [pit_pkg::DIM_W-1:0]     i_shape_height,
    input  logic [pit_pkg::DIM_W-1:0]     i_shape_radius,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pit_pkg::OUT_W-1:0]     o_inertia_x,
    output logic [pit_pkg::OUT_W-1:0]     o_inertia_y,
    output logic [pit_pkg::OUT_W-1:0]     o_inertia_z,
    output logic                          o_saturated
);
    import pit_pkg::*;

    logic                            en;
    logic                            front_v;
    t_div_op [LANES-1:0]             front_ops;
    logic [LANES-1:0][OUT_W-1:0]     quot;

    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    pit_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_opcode       (i_opcode),
        .i_box_length   (i_box_length),
        .i_box_width    (i_box_width),
        .i_shape_height (i_shape_height),
        .i_shape_radius (i_shape_radius),
        .o_valid        (front_v),
        .o_ops          (front_ops)
    );

    pit_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_ops   (front_ops),
        .o_valid (o_out_valid),
        .o_quot  (quot),
        .o_sat   (o_saturated)
    );

    assign o_inertia_x = quot[0];
    assign o_inertia_y = quot[1];
    assign o_inertia_z = quot[2];

    `PIT_ASSERT(a_sat_hits_max, o_out_valid && o_saturated |-> (o_inertia_x == '1 || o_inertia_y == '1 || o_inertia_z == '1), "saturated without a clipped entry")
    `PIT_ASSERT(a_stall_only_full, o_in_stall |-> o_out_valid, "input stalled with no result held")
    `PIT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule
